### sv/slt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// slt_pkg
// Shared constants, codes and types for the sorted list table.
// ----------------------------------------------------------------------------
package slt_pkg;

    // table depth and derived widths
    localparam int CAPACITY = 16;
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    // field widths
    localparam int KIND_W   = 2;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int ECNT_W   = 5;

    // request kinds
    localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
    localparam logic [KIND_W-1:0] KIND_SEARCH = 2'd1;
    localparam logic [KIND_W-1:0] KIND_DELETE = 2'd2;
    localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd3;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_DONE    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_MISSING = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;

    // sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_INS_RD,
        S_INS_CMP,
        S_INS_PUT,
        S_SCAN_RD,
        S_SCAN_CMP
    } t_state;

endpackage
`default_nettype wire

### sv/sorted_list_table_top.sv
// Clear, a full-table insert and an empty-table search or delete answer straight from idle;
// insert compares each entry not below the new value and the first one below it, moving
// the ones not below up, then writes the value; search and delete scan entry by entry.
// Throughput: one word at a time; the next word is taken once the sequencer is back in idle
// and the last result is taken; steps share one read port, one write port, one comparator.
// Reset: synchronous active-low i_rst_n empties the table and drops o_valid.
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sorted_list_table_top
// Ascending table of signed 32-bit values with insert, search, delete and
// clear, worked one entry at a time through a one-read, one-write table memory.
// ----------------------------------------------------------------------------
module sorted_list_table_top (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    // request channel
    input  wire logic                              i_valid,
    output logic                                   o_ready,
    input  wire logic [slt_pkg::KIND_W-1:0]        i_kind,
    input  wire logic signed [slt_pkg::VALUE_W-1:0] i_value,
    // result channel
    output logic                                   o_valid,
    input  wire logic                              i_ready,
    output logic [slt_pkg::STATUS_W-1:0]           o_status,
    output logic                                   o_is_empty,
    output logic [slt_pkg::ECNT_W-1:0]             o_entry_count
);

    localparam int CNT_W = slt_pkg::CNT_W;
    localparam int IDX_W = slt_pkg::IDX_W;
    localparam int VW    = slt_pkg::VALUE_W;

    // table memory and registered read data
    logic [VW-1:0]  r_mem [slt_pkg::CAPACITY];
    logic [VW-1:0]  r_rd_data;

    // sequencer and datapath registers
    slt_pkg::t_state r_state, n_state;
    logic [CNT_W-1:0] r_count, n_count;
    logic [CNT_W-1:0] r_idx, n_idx;
    logic             r_found, n_found;
    logic [slt_pkg::KIND_W-1:0] r_kind;
    logic [VW-1:0]    r_value;

    // result register
    logic                          r_o_valid;
    logic [slt_pkg::STATUS_W-1:0]  r_o_status;
    logic [CNT_W-1:0]              r_o_count;

    // control from the output decode
    logic                          w_accept;
    logic                          w_we;
    logic [IDX_W-1:0]              w_waddr;
    logic [VW-1:0]                 w_wdata;
    logic [IDX_W-1:0]              w_raddr;
    logic                          w_done;
    logic [slt_pkg::STATUS_W-1:0]  w_done_status;

    // shared compare unit and index arithmetic
    logic             w_ge;
    logic             w_hit;
    logic             w_found_now;
    logic [CNT_W-1:0] w_idx_dec;
    logic [CNT_W-1:0] w_idx_inc;
    logic             w_last;
    logic [CNT_W+slt_pkg::ECNT_W-1:0] w_cnt_ext;

    assign w_ge        = $signed(r_rd_data) >= $signed(r_value);
    assign w_hit       = r_rd_data == r_value;
    assign w_found_now = r_found | w_hit;
    assign w_idx_dec   = r_idx - CNT_W'(1);
    assign w_idx_inc   = r_idx + CNT_W'(1);
    assign w_last      = w_idx_inc == r_count;

    assign o_ready  = (r_state == slt_pkg::S_IDLE) && (!r_o_valid || i_ready);
    assign w_accept = i_valid && o_ready;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            slt_pkg::S_IDLE: begin
                if (w_accept) begin
                    case (i_kind)
                        slt_pkg::KIND_INSERT: begin
                            if (r_count >= CNT_W'(slt_pkg::CAPACITY)) begin
                                n_state = slt_pkg::S_IDLE;
                            end else if (r_count == '0) begin
                                n_state = slt_pkg::S_INS_PUT;
                            end else begin
                                n_state = slt_pkg::S_INS_RD;
                            end
                        end
                        slt_pkg::KIND_SEARCH,
                        slt_pkg::KIND_DELETE: begin
                            n_state = (r_count == '0) ? slt_pkg::S_IDLE : slt_pkg::S_SCAN_RD;
                        end
                        default: n_state = slt_pkg::S_IDLE;
                    endcase
                end
            end
            slt_pkg::S_INS_RD:  n_state = slt_pkg::S_INS_CMP;
            slt_pkg::S_INS_CMP: begin
                if (w_ge && (w_idx_dec != '0)) begin
                    n_state = slt_pkg::S_INS_RD;
                end else begin
                    n_state = slt_pkg::S_INS_PUT;
                end
            end
            slt_pkg::S_INS_PUT:  n_state = slt_pkg::S_IDLE;
            slt_pkg::S_SCAN_RD:  n_state = slt_pkg::S_SCAN_CMP;
            slt_pkg::S_SCAN_CMP: begin
                if ((r_kind == slt_pkg::KIND_SEARCH && w_hit) || w_last) begin
                    n_state = slt_pkg::S_IDLE;
                end else begin
                    n_state = slt_pkg::S_SCAN_RD;
                end
            end
            default: n_state = slt_pkg::S_IDLE;
        endcase
    end

    // datapath control and results
    always_comb begin
        w_we          = 1'b0;
        w_waddr       = r_idx[IDX_W-1:0];
        w_wdata       = r_value;
        w_raddr       = r_idx[IDX_W-1:0];
        w_done        = 1'b0;
        w_done_status = slt_pkg::ST_DONE;
        n_count       = r_count;
        n_idx         = r_idx;
        n_found       = r_found;
        case (r_state)
            slt_pkg::S_IDLE: begin
                n_found = 1'b0;
                n_idx   = (i_kind == slt_pkg::KIND_INSERT) ? r_count : '0;
                if (w_accept) begin
                    case (i_kind)
                        slt_pkg::KIND_INSERT: begin
                            if (r_count >= CNT_W'(slt_pkg::CAPACITY)) begin
                                w_done        = 1'b1;
                                w_done_status = slt_pkg::ST_FULL;
                            end
                        end
                        slt_pkg::KIND_SEARCH,
                        slt_pkg::KIND_DELETE: begin
                            if (r_count == '0) begin
                                w_done        = 1'b1;
                                w_done_status = slt_pkg::ST_MISSING;
                            end
                        end
                        default: begin
                            w_done  = 1'b1;
                            n_count = '0;
                        end
                    endcase
                end
            end
            // look at the entry just below the hole
            slt_pkg::S_INS_RD: begin
                w_raddr = w_idx_dec[IDX_W-1:0];
            end
            // entry not below the new value moves up into the hole
            slt_pkg::S_INS_CMP: begin
                if (w_ge) begin
                    w_we    = 1'b1;
                    w_wdata = r_rd_data;
                    n_idx   = w_idx_dec;
                end
            end
            slt_pkg::S_INS_PUT: begin
                w_we    = 1'b1;
                w_done  = 1'b1;
                n_count = r_count + CNT_W'(1);
            end
            slt_pkg::S_SCAN_RD: begin
                w_raddr = r_idx[IDX_W-1:0];
            end
            // on delete, after the first match, every later entry moves down one place
            slt_pkg::S_SCAN_CMP: begin
                n_found = w_found_now;
                n_idx   = w_idx_inc;
                if (r_found && r_kind == slt_pkg::KIND_DELETE) begin
                    w_we    = 1'b1;
                    w_waddr = w_idx_dec[IDX_W-1:0];
                    w_wdata = r_rd_data;
                end
                if (r_kind == slt_pkg::KIND_SEARCH && w_hit) begin
                    w_done = 1'b1;
                end else if (w_last) begin
                    w_done        = 1'b1;
                    w_done_status = w_found_now ? slt_pkg::ST_DONE : slt_pkg::ST_MISSING;
                    if (w_found_now && r_kind == slt_pkg::KIND_DELETE) begin
                        n_count = w_idx_dec + r_count - r_idx;
                    end
                end
            end
            default: ;
        endcase
    end

    // table memory, one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        r_rd_data <= r_mem[w_raddr];
    end

    // sequencer and control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= slt_pkg::S_IDLE;
            r_count   <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (w_done) begin
                r_o_valid <= 1'b1;
            end else if (i_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_idx   <= n_idx;
        r_found <= n_found;
        if (w_accept) begin
            r_kind  <= i_kind;
            r_value <= i_value;
        end
        if (w_done) begin
            r_o_status <= w_done_status;
            r_o_count  <= n_count;
        end
    end

    // result word; count is reported modulo 32
    assign w_cnt_ext     = {{slt_pkg::ECNT_W{1'b0}}, r_o_count};
    assign o_valid       = r_o_valid;
    assign o_status      = r_o_status;
    assign o_is_empty    = r_o_count == '0;
    assign o_entry_count = w_cnt_ext[slt_pkg::ECNT_W-1:0];

endmodule
`default_nettype wire

### sv/slt_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// slt_checker
// Port-level checks on the sorted list table, bound to the top level.
// ----------------------------------------------------------------------------
module slt_checker (
    input wire logic                              i_clk,
    input wire logic                              i_rst_n,
    input wire logic                              i_valid,
    input wire logic                              o_ready,
    input wire logic                              o_valid,
    input wire logic                              i_ready,
    input wire logic [slt_pkg::STATUS_W-1:0]      o_status,
    input wire logic                              o_is_empty,
    input wire logic [slt_pkg::ECNT_W-1:0]        o_entry_count
);

    // stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_status) && $stable(o_entry_count))
        else $error("result word changed while stalled");

    // empty flag agrees with the count
    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (slt_pkg::CAPACITY < 32) |-> o_is_empty == (o_entry_count == '0))
        else $error("empty flag disagrees with entry count");

    // a refused insert only happens on a full table
    a_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == slt_pkg::ST_FULL |->
            o_entry_count == slt_pkg::ECNT_W'(slt_pkg::CAPACITY))
        else $error("full status with table not full");

    // a taken request is either answered at once or keeps the request side busy
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> o_valid || !o_ready)
        else $error("request neither answered nor held busy");

endmodule

bind sorted_list_table_top slt_checker u_slt_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_valid       (i_valid),
    .o_ready       (o_ready),
    .o_valid       (o_valid),
    .i_ready       (i_ready),
    .o_status      (o_status),
    .o_is_empty    (o_is_empty),
    .o_entry_count (o_entry_count)
);
`default_nettype wire
